@@ rtl/spn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package spn_pkg;

   // width of the transaction fields at the ports
   localparam int FIELD_W      = 16;
   localparam int NIBBLE_W     = 4;

   // tick counter width in use; only the low bits of each field take part
   localparam int TICK_WIDTH   = 16;
   localparam int TICK_USED    = (TICK_WIDTH < FIELD_W) ? TICK_WIDTH : FIELD_W;

   localparam int CAL_UNITS     = 56;
   localparam int NIBBLE_OFFSET = 12;
   localparam int NIBBLE_MAX    = 15;

   // quotient bits kept: the top one flags "at least 32", which already clamps
   localparam int QUO_W        = 6;
   localparam int CELL_COUNT   = QUO_W;

   // pulse * 56 + sync / 2 stays below 2^(TICK_USED + 6)
   localparam int NUM_W        = TICK_USED + 6;
   // divisor aligned to the top quotient bit
   localparam int DIV_W        = TICK_USED + QUO_W - 1;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [DIV_W-1:0] dsh;
      logic [QUO_W-1:0] quo;
      logic             zero;
   } spn_stage_type;

endpackage

`default_nettype wire

@@ rtl/spn_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface spn_req_if import spn_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] pulse_ticks;
   logic [FIELD_W-1:0] sync_ticks;

   modport source (output valid, output pulse_ticks, output sync_ticks, input ready);
   modport sink   (input valid, input pulse_ticks, input sync_ticks, output ready);
endinterface

interface spn_rsp_if import spn_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [NIBBLE_W-1:0] nibble;
   logic                zero_divisor;

   modport source (output valid, output nibble, output zero_divisor, input ready);
   modport sink   (input valid, input nibble, input zero_divisor, output ready);
endinterface

`default_nettype wire

@@ rtl/spn_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spn_front import spn_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   spn_req_if.sink       req,
   output logic          dn_valid,
   input  logic          dn_ready,
   output spn_stage_type dn_data
);

   logic                 valid_ff;
   logic                 valid_in;
   spn_stage_type        data_ff;
   spn_stage_type        data_in;
   logic [TICK_USED-1:0] pulse;
   logic [TICK_USED-1:0] sync;
   logic                 take;

   assign pulse     = req.pulse_ticks[TICK_USED-1:0];
   assign sync      = req.sync_ticks[TICK_USED-1:0];
   assign req.ready = !valid_ff || dn_ready;
   assign take      = req.valid && req.ready;

   always_comb begin
      data_in.rem  = NUM_W'(pulse) * NUM_W'(CAL_UNITS) + NUM_W'(sync >> 1);
      data_in.dsh  = DIV_W'(sync) << (QUO_W - 1);
      data_in.quo  = '0;
      data_in.zero = (sync == '0);
      valid_in     = take || (valid_ff && !dn_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

@@ rtl/spn_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spn_cell import spn_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   output logic          up_ready,
   input  spn_stage_type up_data,
   output logic          dn_valid,
   input  logic          dn_ready,
   output spn_stage_type dn_data
);

   logic          valid_ff;
   logic          valid_in;
   spn_stage_type data_ff;
   spn_stage_type data_in;
   logic          ge;
   logic          take;

   assign up_ready = !valid_ff || dn_ready;
   assign take     = up_valid && up_ready;

   // one restoring step: subtract the aligned divisor when it fits
   always_comb begin
      ge           = (up_data.rem >= NUM_W'(up_data.dsh));
      data_in.rem  = ge ? (up_data.rem - NUM_W'(up_data.dsh)) : up_data.rem;
      data_in.dsh  = up_data.dsh >> 1;
      data_in.quo  = {up_data.quo[QUO_W-2:0], ge};
      data_in.zero = up_data.zero;
      valid_in     = take || (valid_ff && !dn_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

@@ rtl/spn_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spn_back import spn_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   output logic          up_ready,
   input  spn_stage_type up_data,
   spn_rsp_if.source     rsp
);

   logic                valid_ff;
   logic                valid_in;
   logic [NIBBLE_W-1:0] nibble_ff;
   logic [NIBBLE_W-1:0] nibble_in;
   logic                zero_ff;
   logic [QUO_W-2:0]    quo_low;
   logic [QUO_W-2:0]    excess;
   logic                take;

   assign up_ready = !valid_ff || rsp.ready;
   assign take     = up_valid && up_ready;
   assign quo_low  = up_data.quo[QUO_W-2:0];

   // clamp the rounded quotient minus the offset to the nibble range; a zero divisor gives zero
   always_comb begin
      excess = quo_low - (QUO_W-1)'(NIBBLE_OFFSET);
      if (up_data.zero) begin
         nibble_in = '0;
      end else if (up_data.quo[QUO_W-1]) begin
         nibble_in = NIBBLE_W'(NIBBLE_MAX);
      end else if (quo_low < (QUO_W-1)'(NIBBLE_OFFSET)) begin
         nibble_in = '0;
      end else if (excess > (QUO_W-1)'(NIBBLE_MAX)) begin
         nibble_in = NIBBLE_W'(NIBBLE_MAX);
      end else begin
         nibble_in = excess[NIBBLE_W-1:0];
      end
      valid_in = take || (valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         nibble_ff <= nibble_in;
         zero_ff   <= up_data.zero;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.nibble       = nibble_ff;
   assign rsp.zero_divisor = zero_ff;

endmodule

`default_nettype wire

@@ rtl/sent_pulse_to_nibble_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | handshake   | payload
// req     | in  | valid/ready | pulse_ticks[15:0], sync_ticks[15:0]
// rsp     | out | valid/ready | nibble[3:0], zero_divisor
//
// One transaction per cycle sustained while rsp is ready: the input stage forms
// pulse*56 + sync/2, six divider cells each resolve one quotient bit, the output
// stage clamps. Every stage carries its own valid and holds under stall, so a
// stage with a bubble still takes new data while rsp waits.
// Synchronous reset clears only the stage valid bits.

module sent_pulse_to_nibble_unit import spn_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   spn_req_if.sink   req,
   spn_rsp_if.source rsp
);

   logic [CELL_COUNT:0] vld;
   logic [CELL_COUNT:0] rdy;
   spn_stage_type       stage [CELL_COUNT+1];

   spn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .dn_valid (vld[0]),
      .dn_ready (rdy[0]),
      .dn_data  (stage[0])
   );

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      spn_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (vld[i]),
         .up_ready (rdy[i]),
         .up_data  (stage[i]),
         .dn_valid (vld[i+1]),
         .dn_ready (rdy[i+1]),
         .dn_data  (stage[i+1])
      );
   end

   spn_back u_back (
      .clock    (clock),
      .reset    (reset),
      .up_valid (vld[CELL_COUNT]),
      .up_ready (rdy[CELL_COUNT]),
      .up_data  (stage[CELL_COUNT]),
      .rsp      (rsp)
   );

`ifndef SYNTHESIS
   a_empty_front_ready: assert property (@(posedge clock) disable iff (reset)
      !vld[0] |-> req.ready)
      else $error("input stage empty but req not ready");

   a_no_loss_first_cell: assert property (@(posedge clock) disable iff (reset)
      (vld[0] && !vld[1]) |=> vld[1])
      else $error("transaction dropped between input stage and first cell");

   a_no_loss_last_cell: assert property (@(posedge clock) disable iff (reset)
      (vld[CELL_COUNT] && !rsp.valid) |=> rsp.valid)
      else $error("transaction dropped between last cell and output stage");

   a_zero_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (vld[CELL_COUNT] && rdy[CELL_COUNT] && stage[CELL_COUNT].zero)
         |=> (rsp.valid && rsp.zero_divisor && rsp.nibble == '0))
      else $error("zero divisor not reported as nibble zero");
`endif

endmodule

`default_nettype wire
